### rtl/mma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

  localparam int DIM_DEF = 8;   // default matrix dimension
  localparam int VAL_W   = 32;  // Q16.16 element width
  localparam int CMD_W   = 2;
  localparam int POS_W   = 3;   // row / column port width
  localparam int DIMR_W  = 4;   // dimension register width
  localparam int CFG_W   = 2;   // configuration index width
  localparam int FRAC_W  = 16;

  localparam logic [DIMR_W-1:0] DIMR_RST = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_LOAD_C  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDC,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

endpackage

`default_nettype wire

### rtl/matrix_multiply_accumulate.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// in_      | input     | in_valid / in_ready  | in_cmd, in_row, in_col, in_value
// out_     | output    | out_valid / out_ready| out_row, out_col, out_sum, out_status, out_last
// cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each in-range load transaction writes its memory entry when accepted. A compute transaction with
// matching inner dimensions accumulates each of the m*n elements in turn (C read, kk MAC
// issues through the single read ports of the A and B memories, then a drain of the
// multiplier and accumulator stages), then emits each element through a read, a load and a
// wait state, the wait state holding through any out_ready stall. A dimension mismatch gives
// its error transaction on the next cycle. Reset (rst_n low, synchronous) clears the C valid
// bits: unwritten C reads as zero, no clearing pass. in_ready is low from compute
// acceptance until the last output transaction is taken; cfg_ready is always high.

module matrix_multiply_accumulate #(
  parameter int DIM = mma_pkg::DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mma_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [mma_pkg::POS_W-1:0]     in_row,
  input  wire logic [mma_pkg::POS_W-1:0]     in_col,
  input  wire logic signed [mma_pkg::VAL_W-1:0] in_value,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mma_pkg::POS_W-1:0]          out_row,
  output logic [mma_pkg::POS_W-1:0]          out_col,
  output logic signed [mma_pkg::VAL_W-1:0]   out_sum,
  output logic                               out_status,
  output logic                               out_last,

  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mma_pkg::CFG_W-1:0]     cfg_index,
  input  wire logic [mma_pkg::DIMR_W-1:0]    cfg_data
);

  import mma_pkg::*;

  localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int DEPTH  = DIM * DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] DIM_A  = ADDR_W'(DIM);
  localparam logic [DIMR_W-1:0] DIM_R  = DIMR_W'(DIM);
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W  = PROD_W - FRAC_W + 1;

  // last index of a dimension register clamped into 1..DIM
  function automatic logic [IDX_W-1:0] dim_lim(input logic [DIMR_W-1:0] d);
    logic [DIMR_W-1:0] dm1;
    dm1 = d - 1'b1;
    if (d == '0) begin
      return '0;
    end else if (d > DIM_R) begin
      return IDX_W'(DIM - 1);
    end else begin
      return dm1[IDX_W-1:0];
    end
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * DIM_A + ADDR_W'(c);
  endfunction

  // configuration
  logic [DIMR_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [IDX_W-1:0]  m_lim, n_lim, k_lim;
  logic              dim_err;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIMR_RST;
      a_cols_r <= DIMR_RST;
      b_rows_r <= DIMR_RST;
      b_cols_r <= DIMR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_A_ROWS: a_rows_r <= cfg_data;
        CFG_A_COLS: a_cols_r <= cfg_data;
        CFG_B_ROWS: b_rows_r <= cfg_data;
        CFG_B_COLS: b_cols_r <= cfg_data;
      endcase
    end
  end

  assign m_lim   = dim_lim(a_rows_r);
  assign k_lim   = dim_lim(a_cols_r);
  assign n_lim   = dim_lim(b_cols_r);
  assign dim_err = (a_cols_r != b_rows_r);

  // input decode
  logic              in_acc;
  logic              ld_ok;
  logic [ADDR_W-1:0] ld_addr;
  logic              ld_a, ld_b, ld_c, go_cmp;

  assign in_acc  = in_valid && in_ready;
  assign ld_ok   = ({1'b0, in_row} < DIM_R) && ({1'b0, in_col} < DIM_R);
  assign ld_addr = addr_of(in_row[IDX_W-1:0], in_col[IDX_W-1:0]);

  always_comb begin
    ld_a   = 1'b0;
    ld_b   = 1'b0;
    ld_c   = 1'b0;
    go_cmp = 1'b0;
    if (in_acc) begin
      unique case (cmd_t'(in_cmd))
        CMD_LOAD_A:  ld_a   = ld_ok;
        CMD_LOAD_B:  ld_b   = ld_ok;
        CMD_LOAD_C:  ld_c   = ld_ok;
        CMD_COMPUTE: go_cmp = 1'b1;
      endcase
    end
  end

  // sequencer
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             elem_last, row_last, k_last;
  logic             iss_vld, acc_init, c_wb, out_ld, out_ld_err;

  // pipeline: memory read -> product -> accumulate
  logic                     v1_r, l1_r, v2_r, l2_r;
  logic signed [VAL_W-1:0]  a_q, b_q;
  logic signed [PROD_W-1:0] p_r, p_nxt;
  logic signed [VAL_W-1:0]  acc_r, acc_sat;
  logic signed [SUM_W-1:0]  sum_w;

  assign elem_last = (j_r == n_lim);
  assign row_last  = (i_r == m_lim);
  assign k_last    = (k_r == k_lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go_cmp) begin
          state_nxt = dim_err ? ST_EMIT_WAIT : ST_RDC;
        end
      end
      ST_RDC:   state_nxt = ST_MAC;
      ST_MAC: begin
        if (k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (v2_r && l2_r) begin
          state_nxt = (elem_last && row_last) ? ST_EMIT_RD : ST_RDC;
        end
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_ready) begin
          state_nxt = out_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    iss_vld    = 1'b0;
    acc_init   = 1'b0;
    c_wb       = 1'b0;
    out_ld     = 1'b0;
    out_ld_err = 1'b0;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        i_nxt    = '0;
        j_nxt    = '0;
        out_ld_err = go_cmp && dim_err;
      end
      ST_RDC: begin
        k_nxt = '0;
      end
      ST_MAC: begin
        iss_vld  = 1'b1;
        acc_init = (k_r == '0);
        k_nxt    = k_r + 1'b1;
      end
      ST_DRAIN: begin
        if (v2_r && l2_r) begin
          c_wb = 1'b1;
          if (elem_last) begin
            j_nxt = '0;
            i_nxt = row_last ? '0 : i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      ST_EMIT_RD: begin
      end
      ST_EMIT_LD: begin
        out_ld = 1'b1;
      end
      ST_EMIT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready && !out_last) begin
          if (elem_last) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
    end
  end

  // A and B memories: load port writes, MAC issue reads
  logic [VAL_W-1:0]  a_mem [DEPTH];
  logic [VAL_W-1:0]  b_mem [DEPTH];
  logic [ADDR_W-1:0] a_raddr, b_raddr, ci_addr;

  assign a_raddr = addr_of(i_r, k_r);
  assign b_raddr = addr_of(k_r, j_r);
  assign ci_addr = addr_of(i_r, j_r);

  always_ff @(posedge clk) begin
    if (ld_a) begin
      a_mem[ld_addr] <= in_value;
    end
    a_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      b_mem[ld_addr] <= in_value;
    end
    b_q <= b_mem[b_raddr];
  end

  // C memory; valid bits make unwritten entries read as zero
  logic [VAL_W-1:0]  c_mem [DEPTH];
  logic [VAL_W-1:0]  c_q;
  logic [DEPTH-1:0]  c_vld_r;
  logic              c_vld_q;
  logic              c_we;
  logic [ADDR_W-1:0] c_waddr;
  logic [VAL_W-1:0]  c_wdata;
  logic signed [VAL_W-1:0] c_rd;

  assign c_we    = ld_c || c_wb;
  assign c_waddr = ld_c ? ld_addr : ci_addr;
  assign c_wdata = ld_c ? in_value : acc_sat;
  assign c_rd    = c_vld_q ? signed'(c_q) : '0;

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    c_q <= c_mem[ci_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= '0;
      c_vld_q <= 1'b0;
    end else begin
      if (c_we) begin
        c_vld_r[c_waddr] <= 1'b1;
      end
      c_vld_q <= c_vld_r[ci_addr];
    end
  end

  // multiply, then shift right 16 (floor) and saturating add
  assign p_nxt   = a_q * b_q;
  assign sum_w   = SUM_W'(acc_r) + SUM_W'(signed'(p_r[PROD_W-1:FRAC_W]));

  always_comb begin
    if (sum_w[SUM_W-1:VAL_W-1] == '0 || sum_w[SUM_W-1:VAL_W-1] == '1) begin
      acc_sat = sum_w[VAL_W-1:0];
    end else if (sum_w[SUM_W-1]) begin
      acc_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      l1_r <= 1'b0;
      v2_r <= 1'b0;
      l2_r <= 1'b0;
    end else begin
      v1_r <= iss_vld;
      l1_r <= iss_vld && k_last;
      v2_r <= v1_r;
      l2_r <= l1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (acc_init) begin
      acc_r <= c_rd;
    end else if (v2_r) begin
      acc_r <= acc_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_ld_err) begin
      out_row    <= '0;
      out_col    <= '0;
      out_sum    <= '0;
      out_status <= 1'b1;
      out_last   <= 1'b1;
    end else if (out_ld) begin
      out_row    <= POS_W'(i_r);
      out_col    <= POS_W'(j_r);
      out_sum    <= c_rd;
      out_status <= 1'b0;
      out_last   <= elem_last && row_last;
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (go_cmp && dim_err) |=> (out_valid && out_status && out_last && out_sum == '0))
    else $error("mismatch did not give a single error result");

  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDC || state_r == ST_IDLE || state_r == ST_EMIT_RD) |-> (!v1_r && !v2_r))
    else $error("MAC pipeline not drained before next C access");

  a_wb_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    c_wb |-> (state_r == ST_DRAIN && !acc_init && !ld_c))
    else $error("C write-back outside drain");

  a_init_first: assert property (@(posedge clk) disable iff (!rst_n)
    acc_init |-> $past(state_r == ST_RDC))
    else $error("accumulator loaded without fresh C read");

endmodule

`default_nettype wire
